### rtl/rlf_pkg.sv
package rlf_pkg;

  typedef logic signed [31:0] q_t;

  localparam logic [17:0] HeatRatioReset = 18'd91750;
  localparam logic signed [32:0] QOne = 33'sd65536;
  localparam logic signed [32:0] QHalf = 33'sd32768;

  // divider: 48-bit magnitude dividend, two quotient bits per stage
  localparam int DivWidth = 48;
  localparam int DivBits = 2;
  localparam int DivSteps = DivWidth / DivBits;
  localparam int DivLat = DivSteps + 1;

  // square root: 32 root bits, two per stage
  localparam int SqrtWidth = 32;
  localparam int SqrtBits = 2;
  localparam int SqrtSteps = SqrtWidth / SqrtBits;
  localparam int SqrtLat = SqrtSteps + 1;

  localparam int SideLat = 2 * DivLat + SqrtLat + 7;

  // per side: w = rho, mn, mt, e and f = side flux, both rotated
  typedef struct packed {
    q_t [3:0] w;
    q_t [3:0] f;
    q_t       lam;
    logic     p_neg;
  } side_res_t;

  function automatic q_t sat_q(input logic signed [65:0] x);
    q_t r;
    if (x > 66'sd2147483647) begin
      r = q_t'(32'h7fff_ffff);
    end else if (x < -66'sd2147483648) begin
      r = q_t'(32'h8000_0000);
    end else begin
      r = q_t'(x[31:0]);
    end
    return r;
  endfunction

  // rounded to nearest, ties upwards, then saturated
  function automatic q_t mul_q(input logic signed [32:0] a, input logic signed [32:0] b);
    logic signed [65:0] p;
    p = a * b;
    p = p + 66'sd32768;
    return sat_q(p >>> 16);
  endfunction

  function automatic q_t add_q(input q_t a, input q_t b);
    return sat_q(66'(a) + 66'(b));
  endfunction

  function automatic q_t sub_q(input q_t a, input q_t b);
    return sat_q(66'(a) - 66'(b));
  endfunction

  function automatic q_t abs_q(input q_t a);
    q_t r;
    if (a[31]) begin
      r = sat_q(-66'(a));
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

### rtl/rlf_if.sv
interface rlf_face_if;
  logic               valid;
  logic               ready;
  logic        [30:0] left_density;
  logic signed [31:0] left_mom_x;
  logic signed [31:0] left_mom_y;
  logic        [30:0] left_energy;
  logic        [30:0] right_density;
  logic signed [31:0] right_mom_x;
  logic signed [31:0] right_mom_y;
  logic        [30:0] right_energy;
  logic signed [31:0] face_x;
  logic signed [31:0] face_y;

  modport source (
    output valid, left_density, left_mom_x, left_mom_y, left_energy,
    output right_density, right_mom_x, right_mom_y, right_energy, face_x, face_y,
    input  ready
  );
  modport sink (
    input  valid, left_density, left_mom_x, left_mom_y, left_energy,
    input  right_density, right_mom_x, right_mom_y, right_energy, face_x, face_y,
    output ready
  );
endinterface

interface rlf_flux_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] flux_mass;
  logic signed [31:0] flux_mom_x;
  logic signed [31:0] flux_mom_y;
  logic signed [31:0] flux_energy;
  logic               fault;

  modport source (
    output valid, flux_mass, flux_mom_x, flux_mom_y, flux_energy, fault,
    input  ready
  );
  modport sink (
    input  valid, flux_mass, flux_mom_x, flux_mom_y, flux_energy, fault,
    output ready
  );
endinterface

### rtl/rlf_div.sv
module rlf_div import rlf_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  q_t          num_i,
  input  logic [31:0] den_i,
  output q_t          quo_o
);

  typedef struct packed {
    logic [31:0]         r;
    logic [DivWidth-1:0] dq;
    logic [31:0]         den;
    logic                neg;
    logic                dz;
  } div_st_t;

  function automatic div_st_t div_stage(input div_st_t s);
    div_st_t     t;
    logic [32:0] rr;
    t = s;
    for (int i = 0; i < DivBits; i++) begin
      rr = {t.r, t.dq[DivWidth-1]};
      t.dq = {t.dq[DivWidth-2:0], 1'b0};
      if (rr >= {1'b0, t.den}) begin
        rr = rr - {1'b0, t.den};
        t.dq[0] = 1'b1;
      end
      t.r = rr[31:0];
    end
    return t;
  endfunction

  function automatic q_t div_out(input div_st_t s);
    q_t r;
    if (s.dz) begin
      r = '0;
    end else if (s.neg) begin
      if (s.dq > DivWidth'(32'h8000_0000)) begin
        r = q_t'(32'h8000_0000);
      end else begin
        r = q_t'(~s.dq[31:0] + 32'd1);
      end
    end else if (s.dq > DivWidth'(32'h7fff_ffff)) begin
      r = q_t'(32'h7fff_ffff);
    end else begin
      r = q_t'(s.dq[31:0]);
    end
    return r;
  endfunction

  div_st_t     st0;
  div_st_t     st_q [DivSteps];
  q_t          quo_q;
  logic [32:0] num_neg;

  always_comb begin
    num_neg = -33'(num_i);
    st0.r   = '0;
    st0.dq  = {(num_i[31] ? num_neg[31:0] : 32'(num_i)), 16'b0};
    st0.den = den_i;
    st0.neg = num_i[31];
    st0.dz  = (den_i == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= div_stage(st0);
      for (int i = 1; i < DivSteps; i++) begin
        st_q[i] <= div_stage(st_q[i-1]);
      end
      quo_q <= div_out(st_q[DivSteps-1]);
    end
  end

  assign quo_o = quo_q;

endmodule

### rtl/rlf_sqrt.sv
module rlf_sqrt import rlf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [2*SqrtWidth-1:0] rad_i,
  output logic [SqrtWidth-1:0]   root_o
);

  typedef struct packed {
    logic [SqrtWidth+1:0]   rem;
    logic [2*SqrtWidth-1:0] rad;
    logic [SqrtWidth-1:0]   root;
  } sq_st_t;

  function automatic sq_st_t sq_stage(input sq_st_t s);
    sq_st_t               t;
    logic [SqrtWidth+3:0] rr;
    logic [SqrtWidth+1:0] trial;
    t = s;
    for (int i = 0; i < SqrtBits; i++) begin
      rr = {t.rem, t.rad[2*SqrtWidth-1 -: 2]};
      t.rad = {t.rad[2*SqrtWidth-3:0], 2'b00};
      trial = {t.root, 2'b01};
      if (rr >= {2'b00, trial}) begin
        rr = rr - {2'b00, trial};
        t.root = {t.root[SqrtWidth-2:0], 1'b1};
      end else begin
        t.root = {t.root[SqrtWidth-2:0], 1'b0};
      end
      t.rem = rr[SqrtWidth+1:0];
    end
    return t;
  endfunction

  sq_st_t                st0;
  sq_st_t                st_q [SqrtSteps];
  logic [SqrtWidth-1:0]  root_q;

  always_comb begin
    st0.rem  = '0;
    st0.rad  = rad_i;
    st0.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= sq_stage(st0);
      for (int i = 1; i < SqrtSteps; i++) begin
        st_q[i] <= sq_stage(st_q[i-1]);
      end
      root_q <= st_q[SqrtSteps-1].root;
    end
  end

  assign root_o = root_q;

endmodule

### rtl/rlf_side.sv
module rlf_side import rlf_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [17:0] gam_i,
  input  q_t          rho_i,
  input  q_t          mn_i,
  input  q_t          mt_i,
  input  q_t          e_i,
  output side_res_t   res_o
);

  localparam int TailLat = DivLat + SqrtLat - 1;

  typedef struct packed {
    q_t [3:0] w;
    q_t       u;
    q_t       a1;
    q_t       f2;
    q_t       x;
    q_t       y;
  } sp_t;

  logic signed [32:0]    gam;
  logic signed [32:0]    gm1;
  q_t                    u;
  q_t                    v;
  q_t                    c2;
  logic [2*SqrtWidth-1:0] rad;
  logic [SqrtWidth-1:0]  a_root;
  q_t [3:0]              w_in;
  q_t [3:0]              wd_q [DivLat];
  sp_t                   m1_q, m2_q, m3_q, m4_q, m5_q, m6_q, m7_q;
  sp_t                   m2_d, m3_d, m4_d, m5_d, m6_d, m7_d;
  q_t                    gp_q;
  sp_t                   tl_q [TailLat];
  sp_t                   tail;
  side_res_t             res_q;

  assign gam  = 33'($signed({1'b0, gam_i}));
  assign gm1  = gam - QOne;
  assign w_in = {e_i, mt_i, mn_i, rho_i};

  rlf_div u_div_u (.clk_i, .en_i, .num_i(mn_i), .den_i(rho_i), .quo_o(u));
  rlf_div u_div_v (.clk_i, .en_i, .num_i(mt_i), .den_i(rho_i), .quo_o(v));

  // sound speed squared, then its root
  rlf_div u_div_c (.clk_i, .en_i, .num_i(gp_q), .den_i(m6_q.w[0]), .quo_o(c2));

  assign rad = (c2 > 0) ? {16'b0, c2, 16'b0} : '0;

  rlf_sqrt u_sqrt (.clk_i, .en_i, .rad_i(rad), .root_o(a_root));

  assign tail = tl_q[TailLat-1];

  always_comb begin
    m2_d   = m1_q;
    m2_d.x = add_q(m1_q.a1, m1_q.x);

    // kinetic energy
    m3_d   = m2_q;
    m3_d.x = mul_q(QHalf, 33'(m2_q.x));

    m4_d   = m3_q;
    m4_d.x = sub_q(m3_q.w[3], m3_q.x);

    // pressure
    m5_d   = m4_q;
    m5_d.x = mul_q(gm1, 33'(m4_q.x));

    m6_d    = m5_q;
    m6_d.a1 = add_q(m5_q.a1, m5_q.x);
    m6_d.y  = add_q(m5_q.w[3], m5_q.x);

    m7_d   = m6_q;
    m7_d.y = mul_q(33'(m6_q.y), 33'(m6_q.u));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wd_q[0] <= w_in;
      for (int i = 1; i < DivLat; i++) begin
        wd_q[i] <= wd_q[i-1];
      end

      m1_q.w  <= wd_q[DivLat-1];
      m1_q.u  <= u;
      m1_q.a1 <= mul_q(33'(wd_q[DivLat-1][1]), 33'(u));
      m1_q.f2 <= mul_q(33'(wd_q[DivLat-1][1]), 33'(v));
      m1_q.x  <= mul_q(33'(wd_q[DivLat-1][2]), 33'(v));
      m1_q.y  <= '0;

      m2_q <= m2_d;
      m3_q <= m3_d;
      m4_q <= m4_d;
      m5_q <= m5_d;
      m6_q <= m6_d;
      gp_q <= mul_q(gam, 33'(m5_q.x));
      m7_q <= m7_d;

      tl_q[0] <= m7_q;
      for (int i = 1; i < TailLat; i++) begin
        tl_q[i] <= tl_q[i-1];
      end

      res_q.w     <= tail.w;
      res_q.f     <= {tail.y, tail.f2, tail.a1, tail.w[1]};
      res_q.lam   <= add_q(abs_q(tail.u), q_t'(a_root));
      res_q.p_neg <= tail.x[31];
    end
  end

  assign res_o = res_q;

endmodule

### rtl/rusanov_euler_face_flux.sv
// channel   dir  payload                                         handshake
// face_i    in   left/right density, momenta, energy; face x/y   valid/ready
// flux_o    out  mass, x/y momentum and energy flux, fault       valid/ready
// cfg       in   heat_ratio, unsigned q2.16                      cfg_we_i
//
// one request per clock while face_i.ready is high; the delay to each result is set by
// the face-length root, the normal division and, per side, two dividers and a root
// reset clears the pipeline, output and skid valid bits and loads heat_ratio = 1.4
// a stalled output parks one result in the skid stage, then the whole pipeline holds
module rusanov_euler_face_flux import rlf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [17:0] cfg_wdata_i,
  rlf_face_if.sink    face_i,
  rlf_flux_if.source  flux_o
);

  localparam int PosN    = 2 + SqrtLat + DivLat;
  localparam int FaceLat = PosN + 2;
  localparam int PosS    = PosN + 2 + SideLat;
  localparam int PosL    = PosS + 7;
  localparam int GeoLat  = PosS + 6 - PosN;

  typedef struct packed {
    logic [30:0] left_density;
    q_t          left_mom_x;
    q_t          left_mom_y;
    logic [30:0] left_energy;
    logic [30:0] right_density;
    q_t          right_mom_x;
    q_t          right_mom_y;
    logic [30:0] right_energy;
    q_t          face_x;
    q_t          face_y;
  } face_t;

  typedef struct packed {
    q_t          nx;
    q_t          ny;
    logic [31:0] len;
  } geo_t;

  typedef struct packed {
    q_t [3:0] flux;
    logic     fault;
  } flux_t;

  logic        en;
  logic [17:0] heat_ratio_q;
  logic [PosL:0] vld_q;
  face_t       in_d, in_q;
  face_t       fd_q [FaceLat];
  face_t       fa, fb;
  logic [63:0] fx2_q, fy2_q, sum_q;
  logic [31:0] len;
  logic [31:0] ld_q [DivLat];
  q_t          nx, ny;
  geo_t        gd_q [GeoLat];
  geo_t        g1, g5, g7;
  q_t [3:0]    rl_q, rr_q;
  q_t          lmn_q, lmt_q, rmn_q, rmt_q;
  side_res_t   sl, sr;
  q_t [3:0]    c1s_q, c1d_q, c2a_q, c2d_q, c3a_q, c3b_q, c4f_q;
  q_t [3:0]    c5f_q, c5p_q, c6r_q, c7o_q;
  q_t          c1m_q, c2h_q;
  logic [6:0]  flt_q;
  flux_t       last, out_q, skid_q;
  logic        out_v_q, skid_v_q, mv;

  assign en           = !skid_v_q;
  assign face_i.ready = en;

  always_comb begin
    in_d.left_density  = face_i.left_density;
    in_d.left_mom_x    = face_i.left_mom_x;
    in_d.left_mom_y    = face_i.left_mom_y;
    in_d.left_energy   = face_i.left_energy;
    in_d.right_density = face_i.right_density;
    in_d.right_mom_x   = face_i.right_mom_x;
    in_d.right_mom_y   = face_i.right_mom_y;
    in_d.right_energy  = face_i.right_energy;
    in_d.face_x        = face_i.face_x;
    in_d.face_y        = face_i.face_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_ratio_q <= HeatRatioReset;
    end else if (cfg_we_i) begin
      heat_ratio_q <= cfg_wdata_i;
    end
  end

  // face length and unit normal
  rlf_sqrt u_sqrt_len (.clk_i, .en_i(en), .rad_i(sum_q), .root_o(len));

  rlf_div u_div_nx (
    .clk_i, .en_i(en), .num_i(fd_q[SqrtLat+1].face_x), .den_i(len), .quo_o(nx)
  );
  rlf_div u_div_ny (
    .clk_i, .en_i(en), .num_i(fd_q[SqrtLat+1].face_y), .den_i(len), .quo_o(ny)
  );

  assign fa = fd_q[PosN-1];
  assign fb = fd_q[FaceLat-1];
  assign g1 = gd_q[PosS-PosN-1];
  assign g5 = gd_q[PosS+4-PosN-1];
  assign g7 = gd_q[GeoLat-1];

  rlf_side u_side_l (
    .clk_i, .en_i(en), .gam_i(heat_ratio_q),
    .rho_i(q_t'({1'b0, fb.left_density})), .mn_i(lmn_q), .mt_i(lmt_q),
    .e_i(q_t'({1'b0, fb.left_energy})), .res_o(sl)
  );
  rlf_side u_side_r (
    .clk_i, .en_i(en), .gam_i(heat_ratio_q),
    .rho_i(q_t'({1'b0, fb.right_density})), .mn_i(rmn_q), .mt_i(rmt_q),
    .e_i(q_t'({1'b0, fb.right_energy})), .res_o(sr)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q    <= in_d;
      fd_q[0] <= in_q;
      for (int i = 1; i < FaceLat; i++) begin
        fd_q[i] <= fd_q[i-1];
      end
      fx2_q <= 64'(in_q.face_x * in_q.face_x);
      fy2_q <= 64'(in_q.face_y * in_q.face_y);
      sum_q <= fx2_q + fy2_q;

      ld_q[0] <= len;
      for (int i = 1; i < DivLat; i++) begin
        ld_q[i] <= ld_q[i-1];
      end

      // rotate momenta into normal and tangent
      rl_q[0] <= mul_q(33'(fa.left_mom_x), 33'(nx));
      rl_q[1] <= mul_q(33'(fa.left_mom_y), 33'(ny));
      rl_q[2] <= mul_q(33'(fa.left_mom_x), -33'(ny));
      rl_q[3] <= mul_q(33'(fa.left_mom_y), 33'(nx));
      rr_q[0] <= mul_q(33'(fa.right_mom_x), 33'(nx));
      rr_q[1] <= mul_q(33'(fa.right_mom_y), 33'(ny));
      rr_q[2] <= mul_q(33'(fa.right_mom_x), -33'(ny));
      rr_q[3] <= mul_q(33'(fa.right_mom_y), 33'(nx));
      lmn_q   <= add_q(rl_q[0], rl_q[1]);
      lmt_q   <= add_q(rl_q[2], rl_q[3]);
      rmn_q   <= add_q(rr_q[0], rr_q[1]);
      rmt_q   <= add_q(rr_q[2], rr_q[3]);

      gd_q[0] <= '{nx: nx, ny: ny, len: ld_q[DivLat-1]};
      for (int i = 1; i < GeoLat; i++) begin
        gd_q[i] <= gd_q[i-1];
      end

      for (int k = 0; k < 4; k++) begin
        c1s_q[k] <= add_q(sl.f[k], sr.f[k]);
        c1d_q[k] <= sub_q(sr.w[k], sl.w[k]);
      end
      c1m_q    <= (sl.lam > sr.lam) ? sl.lam : sr.lam;
      flt_q[0] <= (g1.len == '0) || (sl.w[0] == '0) || (sr.w[0] == '0)
                  || sl.p_neg || sr.p_neg;

      for (int k = 0; k < 4; k++) begin
        c2a_q[k] <= mul_q(QHalf, 33'(c1s_q[k]));
        c3b_q[k] <= mul_q(33'(c2h_q), 33'(c2d_q[k]));
        c4f_q[k] <= sub_q(c3a_q[k], c3b_q[k]);
      end
      c2h_q <= mul_q(QHalf, 33'(c1m_q));
      c2d_q <= c1d_q;
      c3a_q <= c2a_q;

      // rotate back to x and y
      c5f_q    <= c4f_q;
      c5p_q[0] <= mul_q(33'(c4f_q[1]), 33'(g5.nx));
      c5p_q[1] <= mul_q(33'(c4f_q[2]), 33'(g5.ny));
      c5p_q[2] <= mul_q(33'(c4f_q[1]), 33'(g5.ny));
      c5p_q[3] <= mul_q(33'(c4f_q[2]), 33'(g5.nx));

      c6r_q[0] <= c5f_q[0];
      c6r_q[1] <= sub_q(c5p_q[0], c5p_q[1]);
      c6r_q[2] <= add_q(c5p_q[2], c5p_q[3]);
      c6r_q[3] <= c5f_q[3];

      for (int k = 0; k < 4; k++) begin
        c7o_q[k] <= flt_q[5] ? '0 : mul_q(33'(c6r_q[k]), $signed({1'b0, g7.len}));
      end

      flt_q[6:1] <= flt_q[5:0];
    end
  end

  // output register with one skid entry
  assign last = '{flux: c7o_q, fault: flt_q[6]};
  assign mv   = vld_q[PosL] && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[PosL-1:0], face_i.valid};
      end
      priority if (skid_v_q) begin
        if (!out_v_q || flux_o.ready) begin
          skid_v_q <= 1'b0;
          out_v_q  <= 1'b1;
        end
      end else if (mv) begin
        if (out_v_q && !flux_o.ready) begin
          skid_v_q <= 1'b1;
        end else begin
          out_v_q <= 1'b1;
        end
      end else if (flux_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (skid_v_q) begin
      if (!out_v_q || flux_o.ready) begin
        out_q <= skid_q;
      end
    end else if (mv) begin
      if (out_v_q && !flux_o.ready) begin
        skid_q <= last;
      end else begin
        out_q <= last;
      end
    end
  end

  assign flux_o.valid       = out_v_q;
  assign flux_o.flux_mass   = out_q.flux[0];
  assign flux_o.flux_mom_x  = out_q.flux[1];
  assign flux_o.flux_mom_y  = out_q.flux[2];
  assign flux_o.flux_energy = out_q.flux[3];
  assign flux_o.fault       = out_q.fault;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held without an output result");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved while stalled");

  a_skid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !flux_o.ready |=> skid_v_q && $stable(skid_q))
    else $error("skid entry lost while output stalled");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.fault |-> out_q.flux == '0)
    else $error("faulted result carries nonzero flux");
`endif

endmodule
